/* rtl/core/ede_pkg.sv */
// Shared types and constants for the edit distance engine.
// Holds the input/output word layouts and the token passed along the cell chain.
// No dependencies.
package ede_pkg;

  // Default longest reference or candidate string, in bytes
  localparam int MaxLenDefault = 64;
  localparam int SymW          = 8;
  localparam int DistW         = 7;

  // Input word modes
  typedef enum logic [1:0] {
    MODE_REF  = 2'd0,
    MODE_CAND = 2'd1,
    MODE_FIN  = 2'd2
  } mode_e;

  // Kind of token moving down the chain
  typedef enum logic [1:0] {
    TOK_IDLE = 2'd0,
    TOK_REF  = 2'd1,
    TOK_CAND = 2'd2,
    TOK_FIN  = 2'd3
  } tok_e;

  typedef struct packed {
    mode_e            mode;
    logic [SymW-1:0]  symbol;
  } in_word_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             error;
  } out_word_t;

  // Control part of a chain token; cost values travel beside it
  typedef struct packed {
    tok_e             kind;
    logic [SymW-1:0]  sym;
    logic             err;
  } tok_t;

endpackage

/* rtl/core/ede_head.sv */
// Head of the cell chain: decodes input words, tracks lengths and the error flag.
// Feeds column zero of the cost row into the first cell. Uses ede_pkg.
module ede_head
  import ede_pkg::*;
#(
  parameter int MaxLen = MaxLenDefault,
  localparam int CW    = $clog2(MaxLen + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          accept_i,
  input  in_word_t      in_word_i,
  output tok_t          tok_o,
  output logic [CW-1:0] new_o,
  output logic [CW-1:0] old_o
);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] len_q, len_d;
  logic          err_q, err_d;
  tok_t          tok_q, tok_d;
  logic [CW-1:0] new_q, new_d;
  logic [CW-1:0] old_q, old_d;

  // Decode the accepted word into a token and update job counters
  always_comb begin
    cnt_d = cnt_q;
    len_d = len_q;
    err_d = err_q;
    tok_d = '{kind: TOK_IDLE, sym: in_word_i.symbol, err: err_q};
    new_d = cnt_q + CW'(1);
    old_d = cnt_q;
    if (accept_i) begin
      case (in_word_i.mode)
        MODE_REF: begin
          // drop a reference byte once candidates started or storage is full
          if (cnt_q != '0 || len_q == CW'(MaxLen)) begin
            err_d = 1'b1;
          end else begin
            tok_d.kind = TOK_REF;
            len_d      = len_q + CW'(1);
          end
        end
        MODE_CAND: begin
          if (cnt_q == CW'(MaxLen)) begin
            err_d = 1'b1;
          end else begin
            tok_d.kind = TOK_CAND;
            cnt_d      = cnt_q + CW'(1);
          end
        end
        MODE_FIN: begin
          // column zero holds the candidate count: the distance for an empty reference
          tok_d.kind = TOK_FIN;
          new_d      = cnt_q;
          cnt_d      = '0;
          len_d      = '0;
          err_d      = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Job state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      len_q <= '0;
      err_q <= 1'b0;
      tok_q <= '{kind: TOK_IDLE, sym: '0, err: 1'b0};
    end else if (adv_i) begin
      cnt_q <= cnt_d;
      len_q <= len_d;
      err_q <= err_d;
      tok_q <= tok_d;
    end
  end

  // Cost values beside the token
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      new_q <= new_d;
      old_q <= old_d;
    end
  end

  assign tok_o = tok_q;
  assign new_o = new_q;
  assign old_o = old_q;

endmodule

/* rtl/core/ede_cell.sv */
// One cell of the chain: holds one reference byte and its entry of the cost row.
// Updates its entry as candidate tokens pass and hands results to the next cell. Uses ede_pkg.
module ede_cell
  import ede_pkg::*;
#(
  parameter int MaxLen = MaxLenDefault,
  parameter int Idx    = 1,
  localparam int CW    = $clog2(MaxLen + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  tok_t          tok_i,
  input  logic [CW-1:0] new_i,
  input  logic [CW-1:0] old_i,
  output tok_t          tok_o,
  output logic [CW-1:0] new_o,
  output logic [CW-1:0] old_o
);

  localparam int CW1 = CW + 1;

  logic            present_q, present_d;
  logic [CW-1:0]   cost_q, cost_d;
  logic [SymW-1:0] ref_q;
  logic            ref_we;
  tok_t            tok_q, tok_d;
  logic [CW-1:0]   new_q, new_d;
  logic [CW-1:0]   old_q, old_d;

  logic [CW1-1:0]  up_cost, left_cost, sub_cost, min_ab, min_abc;

  // Insert, delete and substitute costs; take the smallest
  always_comb begin
    up_cost   = {1'b0, cost_q} + CW1'(1);
    left_cost = {1'b0, new_i} + CW1'(1);
    sub_cost  = {1'b0, old_i} + CW1'(ref_q != tok_i.sym);
    min_ab    = (left_cost < up_cost) ? left_cost : up_cost;
    min_abc   = (sub_cost < min_ab) ? sub_cost : min_ab;
  end

  // Act on the arriving token
  always_comb begin
    present_d = present_q;
    cost_d    = cost_q;
    ref_we    = 1'b0;
    tok_d     = tok_i;
    new_d     = new_i;
    old_d     = old_i;
    case (tok_i.kind)
      TOK_REF: begin
        // first empty cell takes the byte and consumes the token
        if (!present_q) begin
          present_d  = 1'b1;
          ref_we     = 1'b1;
          tok_d.kind = TOK_IDLE;
        end
      end
      TOK_CAND: begin
        if (present_q) begin
          cost_d = CW'(min_abc);
          new_d  = CW'(min_abc);
          old_d  = cost_q;
        end
      end
      TOK_FIN: begin
        // report this entry if in use, then clear the cell
        if (present_q) begin
          new_d = cost_q;
        end
        present_d = 1'b0;
        cost_d    = CW'(Idx);
      end
      default: begin
      end
    endcase
  end

  // Cell state and the token register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      cost_q    <= CW'(Idx);
      tok_q     <= '{kind: TOK_IDLE, sym: '0, err: 1'b0};
    end else if (adv_i) begin
      present_q <= present_d;
      cost_q    <= cost_d;
      tok_q     <= tok_d;
    end
  end

  // Reference byte and cost values handed on
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      new_q <= new_d;
      old_q <= old_d;
      if (ref_we) begin
        ref_q <= tok_i.sym;
      end
    end
  end

  assign tok_o = tok_q;
  assign new_o = new_q;
  assign old_o = old_q;

endmodule

/* rtl/core/edit_distance_engine.sv */
// Levenshtein edit distance engine: a chain of MaxLen cells, one per reference byte, behind
// a head stage. Every word (reference byte, candidate byte, finish) enters as a token and
// moves one cell per cycle, so one word is taken each cycle while the output is not stalled.
// A candidate byte updates the whole cost row as it sweeps the chain; later candidates follow
// it down the chain. A finish word collects the distance on its way and clears each cell behind
// it; its result word is registered once it has passed the head and every cell register.
// The whole chain halts while a result waits under stall. Uses ede_pkg, ede_head, ede_cell.
module edit_distance_engine
  import ede_pkg::*;
#(
  parameter int MaxLen = MaxLenDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int CW = $clog2(MaxLen + 1);

  logic          adv;
  logic          accept;
  tok_t          tok_c [MaxLen+1];
  logic [CW-1:0] new_c [MaxLen+1];
  logic [CW-1:0] old_c [MaxLen+1];
  logic          out_valid_q;
  out_word_t     out_word_q;

  // Advance the chain unless a result word is held under stall
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  ede_head #(
    .MaxLen (MaxLen)
  ) u_head (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .accept_i  (accept),
    .in_word_i (in_word_i),
    .tok_o     (tok_c[0]),
    .new_o     (new_c[0]),
    .old_o     (old_c[0])
  );

  for (genvar j = 1; j <= MaxLen; j++) begin : g_cell
    ede_cell #(
      .MaxLen (MaxLen),
      .Idx    (j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (tok_c[j-1]),
      .new_i  (new_c[j-1]),
      .old_i  (old_c[j-1]),
      .tok_o  (tok_c[j]),
      .new_o  (new_c[j]),
      .old_o  (old_c[j])
    );
  end

  // Capture a finish token leaving the chain as the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= (tok_c[MaxLen].kind == TOK_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_q.distance <= DistW'(new_c[MaxLen]);
      out_word_q.error    <= tok_c[MaxLen].err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef ASSERT_OFF
  // Input is held back only by a stalled result word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled without a pending result");

  // A new result only comes from a finish token at the chain end
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(tok_c[MaxLen].kind == TOK_FIN))
    else $error("result word without finish token");

  // After delivery, a result is present only if a finish token just left the chain
  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i) |=>
      (!out_valid_q || $past(tok_c[MaxLen].kind == TOK_FIN)))
    else $error("result word repeated");

  // Every reference byte finds a free cell
  a_ref_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_c[MaxLen].kind != TOK_REF)
    else $error("reference byte fell off the chain");
`endif

endmodule

/* bench/edit_distance_engine_tb.sv */
// Testbench for edit_distance_engine: drives reference, candidate and finish words and
// checks each distance word against an in-bench dynamic-programming row tracker.
// Depends on ede_pkg and the edit_distance_engine RTL.
`timescale 1ns / 100ps

module edit_distance_engine_tb;
  import ede_pkg::*;

  localparam int MaxLen       = MaxLenDefault;
  // Finish words see the whole chain before their result appears
  localparam int DrainCycles  = MaxLen + 16;
  localparam int HoldCycles   = 400;
  localparam int CycleLimit   = 400000;
  localparam int MaxReports   = 10;
  // Spare encoding of the mode field; the block must ignore it
  localparam logic [1:0] ModeIgnored = 2'd3;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  edit_distance_engine #(.MaxLen(MaxLen)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // Tracked job state
  logic [SymW-1:0] ref_store [MaxLen];
  int              cost_row  [MaxLen+1];
  int              ref_len;
  int              cand_seen;
  logic            job_error;

  out_word_t expected_distances [$];
  int        mismatch_count = 0;
  int        words_sent     = 0;
  int        cycle_count    = 0;
  int        idle_pct       = 0;
  int        stall_pct      = 0;
  int        hold_requests  = 0;
  int        hold_seen;
  int        hold_left;

  // Clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Drive output stall: long hold on request, random stall otherwise
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_seen   <= 0;
    end else if (hold_seen != hold_requests) begin
      hold_seen   <= hold_requests;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic void flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReports) $display("%s", msg);
  endfunction

  function automatic void clear_job();
    for (int j = 0; j <= MaxLen; j++) cost_row[j] = j;
    ref_len   = 0;
    cand_seen = 0;
    job_error = 1'b0;
  endfunction

  // Update the cost row for one accepted word; queue the distance on finish
  function automatic void track_distance(in_word_t w);
    int        diag;
    int        above;
    int        best;
    int        sub;
    out_word_t res;
    case (w.mode)
      MODE_REF: begin
        if (cand_seen != 0 || ref_len >= MaxLen) begin
          job_error = 1'b1;
        end else begin
          ref_store[ref_len] = w.symbol;
          ref_len++;
        end
      end
      MODE_CAND: begin
        if (cand_seen >= MaxLen) begin
          job_error = 1'b1;
        end else begin
          diag = cost_row[0];
          cand_seen++;
          cost_row[0] = cand_seen;
          for (int j = 1; j <= ref_len; j++) begin
            above = cost_row[j];
            sub   = diag + ((ref_store[j-1] == w.symbol) ? 0 : 1);
            best  = above + 1;
            if (cost_row[j-1] + 1 < best) best = cost_row[j-1] + 1;
            if (sub < best) best = sub;
            cost_row[j] = best;
            diag = above;
          end
        end
      end
      MODE_FIN: begin
        res.distance = DistW'(cost_row[ref_len]);
        res.error    = job_error;
        expected_distances.push_back(res);
        clear_job();
      end
      default: ;
    endcase
  endfunction

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin : check_results
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_distances.size() == 0) begin
        flag_mismatch($sformatf("unexpected word: distance %0d error %0b",
                                out_word_o.distance, out_word_o.error));
      end else begin
        want = expected_distances.pop_front();
        if (out_word_o.distance !== want.distance || out_word_o.error !== want.error) begin
          flag_mismatch($sformatf("mismatch: expected distance %0d error %0b, got %0d %0b",
                                  want.distance, want.error,
                                  out_word_o.distance, out_word_o.error));
        end
      end
    end
  end

  function automatic in_word_t make_word(mode_e m, logic [SymW-1:0] s);
    in_word_t w;
    w.mode   = m;
    w.symbol = s;
    return w;
  endfunction

  function automatic logic [SymW-1:0] pick_symbol(int base, int spread);
    return SymW'(base + $urandom_range(0, spread));
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_distance(w);
    if (w.mode != mode_e'(ModeIgnored)) words_sent++;
  endtask

  // Pause the sender until every expected result has come
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_distances.size() != 0) @(posedge clk_i);
  endtask

  // One job with random lengths and content, some noise and broken order
  task automatic send_random_job();
    int rlen;
    int clen;
    int base;
    int spread;
    rlen   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, MaxLen + 2)
                                          : $urandom_range(0, 8);
    clen   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, MaxLen + 2)
                                          : $urandom_range(0, 8);
    base   = $urandom_range(0, 255);
    spread = $urandom_range(0, 1) ? 3 : 255;
    for (int k = 0; k < rlen; k++) begin
      if ($urandom_range(0, 99) < 8)
        send_word(make_word(mode_e'(ModeIgnored), pick_symbol(0, 255)));
      send_word(make_word(MODE_REF, pick_symbol(base, spread)));
    end
    for (int k = 0; k < clen; k++) begin
      if ($urandom_range(0, 99) < 8)
        send_word(make_word(mode_e'(ModeIgnored), pick_symbol(0, 255)));
      send_word(make_word(MODE_CAND, pick_symbol(base, spread)));
    end
    // Stray reference byte after candidates
    if ($urandom_range(0, 99) < 10)
      send_word(make_word(MODE_REF, pick_symbol(base, spread)));
    if ($urandom_range(0, 99) < 95)
      send_word(make_word(MODE_FIN, pick_symbol(0, 255)));
  endtask

  task automatic test_directed_cases();
    idle_pct  = 0;
    stall_pct = 0;
    // Both strings empty
    send_word(make_word(MODE_FIN, 8'h00));
    // Extreme byte values, swapped order
    send_word(make_word(MODE_REF, 8'h00));
    send_word(make_word(MODE_REF, 8'hFF));
    send_word(make_word(MODE_CAND, 8'hFF));
    send_word(make_word(MODE_CAND, 8'h00));
    send_word(make_word(MODE_FIN, 8'hFF));
    // Exact match
    send_word(make_word(MODE_REF, 8'hA5));
    send_word(make_word(MODE_CAND, 8'hA5));
    send_word(make_word(MODE_FIN, 8'h5A));
    // Empty reference
    send_word(make_word(MODE_CAND, 8'h12));
    send_word(make_word(MODE_CAND, 8'h34));
    send_word(make_word(MODE_FIN, 8'h00));
    // Empty candidate
    send_word(make_word(MODE_REF, 8'h01));
    send_word(make_word(MODE_REF, 8'h02));
    send_word(make_word(MODE_REF, 8'h03));
    send_word(make_word(MODE_FIN, 8'h00));
    // Unused mode, then a reference byte after a candidate
    send_word(make_word(mode_e'(ModeIgnored), 8'hFF));
    send_word(make_word(MODE_REF, 8'h07));
    send_word(make_word(MODE_CAND, 8'h08));
    send_word(make_word(MODE_REF, 8'h07));
    send_word(make_word(mode_e'(ModeIgnored), 8'h00));
    send_word(make_word(MODE_FIN, 8'h00));
    wait_drained();
  endtask

  task automatic test_length_limits();
    idle_pct  = 0;
    stall_pct = 0;
    // Full-length mismatch, then one byte too many on each side
    for (int k = 0; k <= MaxLen; k++) send_word(make_word(MODE_REF, 8'h00));
    for (int k = 0; k <= MaxLen; k++) send_word(make_word(MODE_CAND, 8'hFF));
    send_word(make_word(MODE_FIN, 8'h00));
    // Full-length strings of random content within limits
    for (int k = 0; k < MaxLen; k++) send_word(make_word(MODE_REF, pick_symbol(0, 255)));
    for (int k = 0; k < MaxLen; k++) send_word(make_word(MODE_CAND, pick_symbol(0, 255)));
    send_word(make_word(MODE_FIN, 8'h00));
    wait_drained();
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    // Hold the output for a long stretch while jobs keep coming
    hold_requests <= hold_requests + 1;
    for (int n = 0; n < 4; n++) begin
      for (int k = 0; k < 4; k++) send_word(make_word(MODE_REF, pick_symbol('h40, 3)));
      for (int k = 0; k < 4; k++) send_word(make_word(MODE_CAND, pick_symbol('h40, 3)));
      send_word(make_word(MODE_FIN, 8'h00));
    end
    wait_drained();
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int count);
    int start;
    idle_pct  = idle;
    stall_pct = stall;
    start     = words_sent;
    while (words_sent - start < count) send_random_job();
    // Close any job left without a finish
    send_word(make_word(MODE_FIN, 8'h00));
    wait_drained();
  endtask

  initial begin
    clear_job();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_length_limits();
    test_backpressure();
    test_random_traffic(0, 0, 70);
    test_random_traffic(84, 0, 70);
    test_random_traffic(0, 84, 70);
    test_random_traffic(24, 24, 70);

    stall_pct = 0;
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_distances.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_distances.size()));
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ede_pkg.sv
rtl/core/ede_head.sv
rtl/core/ede_cell.sv
rtl/core/edit_distance_engine.sv
bench/edit_distance_engine_tb.sv
